>>> hdl/ib32_pkg.sv
// Shared types, constants and helpers for the interleaved base32 decoder.
// No dependencies; imported by every module of the block.
package ib32_pkg;

    localparam int SYM_W        = 5;
    localparam int GROUP_SYMS   = 8;
    localparam int GROUP_BYTES  = 5;
    localparam int WORD_W       = GROUP_BYTES * 8;
    localparam int HELD_SYMS    = GROUP_SYMS - 1;

    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_5 = 8'd53;
    localparam logic [7:0] DIGIT_OFFSET = 8'd22;
    localparam logic [7:0] MARKER_BYTE  = 8'd128;

    localparam logic [2:0] LAST_SLOT    = 3'd7;
    localparam logic [2:0] FULL_COUNT   = 3'd5;

    // One unit of work handed from the front end to the byte emitter.
    typedef struct packed {
        logic [WORD_W-1:0] word;       // 40 decoded bits, byte 0 in the top
        logic [2:0]        count;      // results to emit, 1..5
        logic              final_grp;  // bytes belong to the stream's last group
        logic              trunc;      // truncation notice, word is zero
    } ib32_job_t;

    // Byte k of a decoded group, most significant byte first.
    function automatic logic [7:0] grp_byte(input logic [WORD_W-1:0] word,
                                            input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = word[39:32];
            3'd1:    b = word[31:24];
            3'd2:    b = word[23:16];
            3'd3:    b = word[15:8];
            3'd4:    b = word[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/interleaved_base32_decoder_unit.sv
// Top level of the interleaved base32 decoder.
// Depends on ib32_pkg, ib32_front, ib32_job_fifo and ib32_back.
//
// Queue-style block: push a symbol when full is low, pop a decoded byte
// while empty is low. Symbols 'a'..'z' map to 0..25, '0'..'5' to 26..31,
// anything else keeps its low five bits. Eight symbols form a group; each
// pair gives ten bits with the first symbol on the odd positions, and the
// group yields five bytes, first byte first. When stream_end comes with the
// eighth symbol, only the bytes in front of the highest-index 0x80 marker
// come out (none if there is no marker, or it is the first byte), flagged
// from_final_group. When stream_end comes earlier, the partial group is
// dropped and a single transaction with truncated high and data zero is
// returned. last_in_run marks the final byte caused by one input symbol.
// Rate: one symbol per clock is taken as long as the job queue has room;
// the emitter drains one byte per clock while each byte is popped as it
// shows, and a group of eight symbols yields at most five bytes, so a
// steady stream runs at one symbol per cycle. The first byte of a group
// passes through the queue slot, the emitter's current-job register and
// the output register before it shows on the result ports. JOB_DEPTH sets
// how many finished groups may wait while the result side stalls.

module interleaved_base32_decoder_unit
    import ib32_pkg::*;
#(
    parameter int JOB_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  symbol,
    input  logic        stream_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data_byte,
    output logic        last_in_run,
    output logic        from_final_group,
    output logic        truncated
);

    logic      accept;
    logic      job_push;
    ib32_job_t front_job;
    ib32_job_t queued_job;
    logic      job_avail;
    logic      job_take;

    // A symbol enters only while the queue can take the job it may make.
    assign accept = push && !full;

    ib32_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .symbol     (symbol),
        .stream_end (stream_end),
        .job_push   (job_push),
        .job        (front_job)
    );

    ib32_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_push),
        .wr_job    (front_job),
        .full      (full),
        .rd_en     (job_take),
        .rd_job    (queued_job),
        .not_empty (job_avail)
    );

    ib32_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_avail        (job_avail),
        .job              (queued_job),
        .job_take         (job_take),
        .empty            (empty),
        .pop              (pop),
        .data_byte        (data_byte),
        .last_in_run      (last_in_run),
        .from_final_group (from_final_group),
        .truncated        (truncated)
    );

endmodule

>>> hdl/ib32_front.sv
// Front end: accepts symbols, maps them, holds the open group and builds jobs.
// Depends on ib32_pkg.
module ib32_front
    import ib32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  symbol,
    input  logic        stream_end,
    output logic        job_push,
    output ib32_job_t   job
);

    logic [SYM_W-1:0] sym_reg [HELD_SYMS];
    logic [2:0]       group_count_reg;
    logic [2:0]       group_count_next;
    logic [SYM_W-1:0] sym_mapped;
    logic [SYM_W-1:0] grp [GROUP_SYMS];
    logic [WORD_W-1:0] word;
    logic [2:0]       marker_cnt;
    logic             group_done;

    function automatic logic [SYM_W-1:0] map_symbol(input logic [7:0] s);
        logic [7:0] v;
        if (s >= CHAR_LOWER_A && s <= CHAR_LOWER_Z)
        begin
            v = s - CHAR_LOWER_A;
        end
        else if (s >= CHAR_DIGIT_0 && s <= CHAR_DIGIT_5)
        begin
            v = s - DIGIT_OFFSET;
        end
        else
        begin
            v = s;
        end
        return v[SYM_W-1:0];
    endfunction

    assign sym_mapped = map_symbol(symbol);
    assign group_done = (group_count_reg == LAST_SLOT);

    always_comb
    begin
        for (int i = 0; i < HELD_SYMS; i++)
        begin
            grp[i] = sym_reg[i];
        end
        grp[GROUP_SYMS-1] = sym_mapped;
    end

    // Pair (x, y) gives x4 y4 x3 y3 ... x0 y0: odd bits from x, even from y.
    always_comb
    begin
        word = '0;
        for (int p = 0; p < GROUP_SYMS / 2; p++)
        begin
            for (int b = 0; b < SYM_W; b++)
            begin
                word[WORD_W - 10 * (p + 1) + 2 * b + 1] = grp[2 * p][b];
                word[WORD_W - 10 * (p + 1) + 2 * b]     = grp[2 * p + 1][b];
            end
        end
    end

    // Bytes before the highest-index marker; none if the marker is absent.
    always_comb
    begin
        marker_cnt = 3'd0;
        for (int k = 0; k < GROUP_BYTES; k++)
        begin
            if (grp_byte(word, 3'(k)) == MARKER_BYTE)
            begin
                marker_cnt = 3'(k);
            end
        end
    end

    always_comb
    begin
        job              = '0;
        job_push         = 1'b0;
        group_count_next = group_count_reg;
        if (accept)
        begin
            if (!group_done)
            begin
                if (stream_end)
                begin
                    job.count        = 3'd1;
                    job.trunc        = 1'b1;
                    job_push         = 1'b1;
                    group_count_next = 3'd0;
                end
                else
                begin
                    group_count_next = group_count_reg + 3'd1;
                end
            end
            else
            begin
                job.word         = word;
                group_count_next = 3'd0;
                if (stream_end)
                begin
                    job.count     = marker_cnt;
                    job.final_grp = 1'b1;
                    job_push      = (marker_cnt != 3'd0);
                end
                else
                begin
                    job.count = FULL_COUNT;
                    job_push  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= 3'd0;
        end
        else
        begin
            group_count_reg <= group_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !group_done && !stream_end)
        begin
            sym_reg[group_count_reg] <= sym_mapped;
        end
    end

endmodule

>>> hdl/ib32_job_fifo.sv
// Short job queue between front end and byte emitter.
// Depends on ib32_pkg.
module ib32_job_fifo
    import ib32_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  ib32_job_t wr_job,
    output logic      full,
    input  logic      rd_en,
    output ib32_job_t rd_job,
    output logic      not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ib32_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_job    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> hdl/ib32_back.sv
// Byte emitter: walks each job one byte per cycle into the output register while it is empty or popped.
// Depends on ib32_pkg.
module ib32_back
    import ib32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_avail,
    input  ib32_job_t   job,
    output logic        job_take,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data_byte,
    output logic        last_in_run,
    output logic        from_final_group,
    output logic        truncated
);

    ib32_job_t  cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       fin_reg, fin_next;
    logic       trunc_reg, trunc_next;
    logic       advance, cur_last;

    assign advance  = cur_valid_reg && (!out_valid_reg || pop);
    assign cur_last = ((idx_reg + 3'd1) == cur_reg.count);
    assign job_take = job_avail && (!cur_valid_reg || (advance && cur_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        fin_next       = fin_reg;
        trunc_next     = trunc_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            data_next      = grp_byte(cur_reg.word, idx_reg);
            last_next      = cur_last;
            fin_next       = cur_reg.final_grp;
            trunc_next     = cur_reg.trunc;
            idx_next       = idx_reg + 3'd1;
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (job_take)
        begin
            cur_next       = job;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
        fin_reg   <= fin_next;
        trunc_reg <= trunc_next;
    end

    assign empty            = !out_valid_reg;
    assign data_byte        = data_reg;
    assign last_in_run      = last_reg;
    assign from_final_group = fin_reg;
    assign truncated        = trunc_reg;

endmodule
